### design/rrcm_pkg.sv
package rrcm_pkg;

  // input item: one led coordinate
  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } in_item_t;

  // result item: grb colour bytes
  typedef struct packed {
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic [7:0] blue_byte;
  } out_item_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CENTER_X   = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y   = 2'd1;
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;
  localparam logic [1:0] CFG_RING_PHASE = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0] CENTER_X_RST   = 8'd112;
  localparam logic [7:0] CENTER_Y_RST   = 8'd32;
  localparam logic [6:0] BRIGHTNESS_RST = 7'd0;
  localparam logic [3:0] RING_PHASE_RST = 4'd0;

  localparam int RING_COUNT = 12;

  // squared distance thresholds between ring groups
  localparam logic [15:0] RING_LIMIT [RING_COUNT] = '{
    16'd400,   16'd1600,  16'd3600,  16'd6400,
    16'd10000, 16'd14400, 16'd19600, 16'd25600,
    16'd32800, 16'd40000, 16'd48400, 16'd57600
  };

  // hue mix factors, packed as {red, green, blue}
  typedef struct packed {
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
  } hue_mix_t;

  localparam hue_mix_t HUE_MIX [RING_COUNT] = '{
    '{3'd4, 3'd0, 3'd0}, '{3'd3, 3'd1, 3'd0}, '{3'd2, 3'd2, 3'd0},
    '{3'd1, 3'd3, 3'd0}, '{3'd0, 3'd4, 3'd0}, '{3'd0, 3'd3, 3'd1},
    '{3'd0, 3'd2, 3'd2}, '{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd0, 3'd4},
    '{3'd1, 3'd0, 3'd3}, '{3'd2, 3'd0, 3'd2}, '{3'd3, 3'd0, 3'd1}
  };

endpackage

### design/radial_ring_color_mapper_top.sv
// throughput: one item per cycle while out_stall is low, set by the four-stage pipeline with no shared unit
// stages: offsets, squares, ring group, colour index with channel mix
// reset (rst, synchronous, active high) empties all stages and loads the
// configuration registers with their reset values
module radial_ring_color_mapper_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrcm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrcm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // configuration registers
  logic [7:0] center_x;
  logic [7:0] center_y;
  logic [6:0] brightness;
  logic [3:0] ring_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= rrcm_pkg::CENTER_X_RST;
      center_y   <= rrcm_pkg::CENTER_Y_RST;
      brightness <= rrcm_pkg::BRIGHTNESS_RST;
      ring_phase <= rrcm_pkg::RING_PHASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrcm_pkg::CFG_CENTER_X:   center_x   <= cfg_data;
        rrcm_pkg::CFG_CENTER_Y:   center_y   <= cfg_data;
        rrcm_pkg::CFG_BRIGHTNESS: brightness <= cfg_data[6:0];
        rrcm_pkg::CFG_RING_PHASE: ring_phase <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) out_valid <= v3;
    end
  end

  // stage 1: signed offsets from the centre, vertical scaled by three
  logic signed [8:0]  diff_x_next;
  logic signed [8:0]  diff_y_next;
  logic signed [10:0] diff_y_ext;
  logic signed [10:0] dy_next;
  logic signed [8:0]  dx;
  logic signed [10:0] dy;

  assign diff_x_next = $signed({1'b0, in_data.pixel_x}) - $signed({1'b0, center_x});
  assign diff_y_next = $signed({1'b0, in_data.pixel_y}) - $signed({1'b0, center_y});
  assign diff_y_ext  = {{2{diff_y_next[8]}}, diff_y_next};
  assign dy_next     = (diff_y_ext <<< 1) + diff_y_ext;

  always_ff @(posedge clk) begin
    if (adv1) begin
      dx <= diff_x_next;
      dy <= dy_next;
    end
  end

  // stage 2: squares
  logic signed [17:0] sq_x_full;
  logic signed [21:0] sq_y_full;
  logic [16:0]        sq_x;
  logic [19:0]        sq_y;

  assign sq_x_full = dx * dx;
  assign sq_y_full = dy * dy;

  always_ff @(posedge clk) begin
    if (adv2) begin
      sq_x <= sq_x_full[16:0];
      sq_y <= sq_y_full[19:0];
    end
  end

  // stage 3: squared distance and ring group by threshold count
  logic [20:0] sq_dist;
  logic [3:0]  group_next;
  logic [3:0]  ring_group;

  assign sq_dist = {4'd0, sq_x} + {1'b0, sq_y};

  always_comb begin
    group_next = 4'd0;
    for (int i = 0; i < rrcm_pkg::RING_COUNT; i++) begin
      if (sq_dist >= {5'd0, rrcm_pkg::RING_LIMIT[i]}) group_next = group_next + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) ring_group <= group_next;
  end

  // stage 4: colour index modulo twelve, hue mix and byte packing
  logic [4:0]         idx_sum;
  logic [3:0]         color_idx;
  rrcm_pkg::hue_mix_t mix;
  logic [7:0]         lv;
  logic [9:0]         chan_r, chan_g, chan_b;
  rrcm_pkg::out_item_t out_next;

  assign idx_sum = {1'b0, ring_group} + {1'b0, ring_phase};

  always_comb begin
    if (idx_sum >= 5'd24)      color_idx = 4'(idx_sum - 5'd24);
    else if (idx_sum >= 5'd12) color_idx = 4'(idx_sum - 5'd12);
    else                       color_idx = idx_sum[3:0];
  end

  assign mix    = rrcm_pkg::HUE_MIX[color_idx];
  assign lv     = {brightness, 1'b0};
  assign chan_r = 10'({2'd0, lv} * {7'd0, mix.r});
  assign chan_g = 10'({2'd0, lv} * {7'd0, mix.g});
  assign chan_b = 10'({2'd0, lv} * {7'd0, mix.b});

  assign out_next.green_byte = chan_g[7:0] | {6'd0, chan_b[9:8]};
  assign out_next.red_byte   = chan_r[7:0] | {6'd0, chan_g[9:8]};
  assign out_next.blue_byte  = chan_b[7:0];

  always_ff @(posedge clk) begin
    if (adv4) out_data <= out_next;
  end

endmodule
